### sv/fct_pkg.sv
// Shared types, constants and helpers for the frustum cull test block.
package fct_pkg;

	localparam int PLANE_COUNT     = 6;
	localparam int AXIS_COUNT      = 3;
	localparam int PLANE_FIELD     = 16;
	localparam int PLANE_WIDTH     = PLANE_FIELD * 4;
	localparam int W_PART          = 3;
	localparam int FRAC_BITS       = 8;
	localparam int COORD_WIDTH_DEF = 16;
	localparam int CFG_INDEX_WIDTH = 3;

	typedef enum logic [1:0] {
		KIND_POINT     = 2'd0,
		KIND_SPHERE    = 2'd1,
		KIND_BOX       = 2'd2,
		KIND_POINT_ALT = 2'd3
	} kind_t;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		CFG_NEAR   = 3'd0,
		CFG_FAR    = 3'd1,
		CFG_BOTTOM = 3'd2,
		CFG_TOP    = 3'd3,
		CFG_LEFT   = 3'd4,
		CFG_RIGHT  = 3'd5
	} cfg_index_t;

	typedef logic [PLANE_WIDTH-1:0] plane_t;

	typedef struct packed {
		kind_t kind;
		logic  last;
	} side_t;

	// Pick one signed Q7.8 field (nx, ny, nz or w) out of a packed plane.
	function automatic logic signed [PLANE_FIELD-1:0] plane_part(plane_t p, int idx);
		return p[idx*PLANE_FIELD +: PLANE_FIELD];
	endfunction

endpackage

### sv/fct_mult.sv
// Product stage: every plane normal component times the matching a and b coordinate.
module fct_mult import fct_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	localparam int PROD_WIDTH = PLANE_FIELD + COORD_WIDTH
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [COORD_WIDTH-1:0] a [AXIS_COUNT],
	input  logic signed [COORD_WIDTH-1:0] b [AXIS_COUNT],
	input  plane_t                        planes [PLANE_COUNT],
	output logic signed [PROD_WIDTH-1:0]  pa_s2 [PLANE_COUNT][AXIS_COUNT],
	output logic signed [PROD_WIDTH-1:0]  pb_s2 [PLANE_COUNT][AXIS_COUNT]
);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < PLANE_COUNT; i++) begin
				for (int j = 0; j < AXIS_COUNT; j++) begin
					pa_s2[i][j] <= plane_part(planes[i], j) * a[j];
					pb_s2[i][j] <= plane_part(planes[i], j) * b[j];
				end
			end
		end
	end

endmodule

### sv/fct_accum.sv
// Sum stage: positive-vertex select, per-plane distance and the pass limit.
module fct_accum import fct_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	localparam int PROD_WIDTH = PLANE_FIELD + COORD_WIDTH,
	localparam int SUM_WIDTH  = PROD_WIDTH + 3
) (
	input  logic                          clk,
	input  logic                          en,
	input  side_t                         side,
	input  logic        [COORD_WIDTH-2:0] radius,
	input  logic signed [PROD_WIDTH-1:0]  pa [PLANE_COUNT][AXIS_COUNT],
	input  logic signed [PROD_WIDTH-1:0]  pb [PLANE_COUNT][AXIS_COUNT],
	input  plane_t                        planes [PLANE_COUNT],
	output logic signed [SUM_WIDTH-1:0]   d_s3 [PLANE_COUNT],
	output logic signed [SUM_WIDTH-1:0]   lim_s3
);

	logic signed [SUM_WIDTH-1:0] sum_c [PLANE_COUNT];
	logic signed [SUM_WIDTH-1:0] lim_c;
	logic signed [SUM_WIDTH-1:0] rad_c;

	always_comb begin
		for (int i = 0; i < PLANE_COUNT; i++) begin
			// offset moves from Q.8 to Q.16 to line up with the products
			sum_c[i] = SUM_WIDTH'(plane_part(planes[i], W_PART)) <<< FRAC_BITS;
			for (int j = 0; j < AXIS_COUNT; j++) begin
				if (side.kind == KIND_BOX && pb[i][j] > pa[i][j]) begin
					sum_c[i] = sum_c[i] + SUM_WIDTH'(pb[i][j]);
				end else begin
					sum_c[i] = sum_c[i] + SUM_WIDTH'(pa[i][j]);
				end
			end
		end
		rad_c = $signed(SUM_WIDTH'({radius, FRAC_BITS'(0)}));
		lim_c = (side.kind == KIND_SPHERE) ? -rad_c : '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s3   <= sum_c;
			lim_s3 <= lim_c;
		end
	end

endmodule

### sv/frustum_cull_test_unit.sv
// Frustum cull test top level: plane registers, four-stage pipeline and handshake.
//
// Usage:
//   Load the six planes through cfg_we / cfg_index / cfg_data while the block
//   is idle; index 0..5 is near, far, bottom, top, left, right, each packed
//   nx, ny, nz, w (signed Q7.8) from low to high. Other indexes are ignored.
//   Primitives enter on the in channel (transfer when in_valid and !in_stall).
//   Each one yields one result on the out channel (transfer when out_valid and
//   !out_stall): inside_res set when all six planes pass, last_out a copy of
//   last_in.
//   Pipeline: input register, products, sums, compare. One item per cycle is
//   sustained while out_stall is low; the product stage has one multiplier
//   per plane, axis and bound.
//   When the receiver stalls, the pipeline fills its empty stages and then
//   raises in_stall; nothing is dropped or repeated.
//   Reset clears all valid bits and sets every plane to zero, which makes
//   every primitive pass until planes are written.
//
module frustum_cull_test_unit import fct_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
	input  logic [PLANE_WIDTH-1:0]        cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    kind,
	input  logic signed [COORD_WIDTH-1:0] ax,
	input  logic signed [COORD_WIDTH-1:0] ay,
	input  logic signed [COORD_WIDTH-1:0] az,
	input  logic signed [COORD_WIDTH-1:0] bx,
	input  logic signed [COORD_WIDTH-1:0] by,
	input  logic signed [COORD_WIDTH-1:0] bz,
	input  logic        [COORD_WIDTH-2:0] radius,
	input  logic                          last_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          inside_res,
	output logic                          last_out
);

	localparam int PROD_WIDTH = PLANE_FIELD + COORD_WIDTH;
	localparam int SUM_WIDTH  = PROD_WIDTH + 3;

	plane_t planes_q [PLANE_COUNT];

	logic v_s1, v_s2, v_s3, v_s4;
	logic adv1, adv2, adv3, adv4;

	side_t                         side_s1, side_s2, side_s3;
	logic signed [COORD_WIDTH-1:0] a_s1 [AXIS_COUNT];
	logic signed [COORD_WIDTH-1:0] b_s1 [AXIS_COUNT];
	logic        [COORD_WIDTH-2:0] r_s1, r_s2;

	logic signed [PROD_WIDTH-1:0]  pa_s2 [PLANE_COUNT][AXIS_COUNT];
	logic signed [PROD_WIDTH-1:0]  pb_s2 [PLANE_COUNT][AXIS_COUNT];
	logic signed [SUM_WIDTH-1:0]   d_s3 [PLANE_COUNT];
	logic signed [SUM_WIDTH-1:0]   lim_s3;

	logic pass_c;
	logic inside_s4, last_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PLANE_COUNT; i++) begin
				planes_q[i] <= '0;
			end
		end else if (cfg_we && cfg_index <= CFG_RIGHT) begin
			planes_q[cfg_index] <= cfg_data;
		end
	end

	// a stage advances when it is empty or the next one advances
	assign adv4     = !v_s4 || !out_stall;
	assign adv3     = !v_s3 || adv4;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			side_s1 <= '{kind: kind_t'(kind), last: last_in};
			a_s1[0] <= ax;
			a_s1[1] <= ay;
			a_s1[2] <= az;
			b_s1[0] <= bx;
			b_s1[1] <= by;
			b_s1[2] <= bz;
			r_s1    <= radius;
		end
		if (adv2) begin
			side_s2 <= side_s1;
			r_s2    <= r_s1;
		end
		if (adv3) begin
			side_s3 <= side_s2;
		end
		if (adv4) begin
			inside_s4 <= pass_c;
			last_s4   <= side_s3.last;
		end
	end

	fct_mult #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_mult (
		.clk    (clk),
		.en     (adv2),
		.a      (a_s1),
		.b      (b_s1),
		.planes (planes_q),
		.pa_s2  (pa_s2),
		.pb_s2  (pb_s2)
	);

	fct_accum #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_accum (
		.clk    (clk),
		.en     (adv3),
		.side   (side_s2),
		.radius (r_s2),
		.pa     (pa_s2),
		.pb     (pb_s2),
		.planes (planes_q),
		.d_s3   (d_s3),
		.lim_s3 (lim_s3)
	);

	always_comb begin
		pass_c = 1'b1;
		for (int i = 0; i < PLANE_COUNT; i++) begin
			if (d_s3[i] < lim_s3) pass_c = 1'b0;
		end
	end

	assign out_valid  = v_s4;
	assign inside_res = inside_s4;
	assign last_out   = last_s4;

`ifndef SYNTHESIS
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && v_s4))
		else $error("input stalled while a pipeline stage is empty");

	a_s3_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && adv4) |=> (out_valid && last_out == $past(side_s3.last)))
		else $error("item lost between sum stage and output");

	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !v_s3) |=> !out_valid)
		else $error("result repeated after transfer");
`endif

endmodule
